// ===== sv/white_object_region_locator_top_macros.svh =====
// assertion macros shared by the checker
`ifndef WHITE_OBJECT_REGION_LOCATOR_TOP_MACROS_SVH
`define WHITE_OBJECT_REGION_LOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define WOL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wol_pkg.sv =====
package wol_pkg;

  localparam int unsigned POS_W     = 12;
  localparam int unsigned CNT_W     = 24;
  localparam int unsigned LIMIT_W   = 25;
  localparam int unsigned THR_W     = 8;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TOTAL_W   = CNT_W + 2;

  localparam int unsigned MAX_DIMENSION_DEF = 4095;

  localparam logic [POS_W-1:0]   WIDTH_RST = 12'd640;
  localparam logic [POS_W-1:0]   HEIGHT_RST = 12'd480;
  localparam logic [THR_W-1:0]   THRESH_RST = 8'd220;
  localparam logic [LIMIT_W-1:0] CLOSE_RST = 25'd368640;

  // ceil(2^17 / 3), exact quotient for any input below 2^17
  localparam logic [16:0] DIV3_MUL = 17'd43691;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_THRESH = 3'd2,
    REG_CLOSE  = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BAND_LEFT   = 3'b001,
    BAND_CENTRE = 3'b010,
    BAND_RIGHT  = 3'b100
  } band_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic object_left;
    logic object_centre;
    logic object_right;
  } result_t;

  // classified pixel handed from tracker to counters
  typedef struct packed {
    logic  valid;
    logic  white;
    band_t band;
    logic  frame_end;
  } pix_word_t;

  // final band counts of a finished frame
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] centre;
    logic [CNT_W-1:0] right;
  } fin_word_t;

  function automatic logic [POS_W-1:0] div3(input logic [POS_W:0] x);
    logic [POS_W+16:0] prod;
    prod = (POS_W+17)'(x) * (POS_W+17)'(DIV3_MUL);
    return prod[POS_W+16:17];
  endfunction

endpackage

// ===== sv/wol_track.sv =====
module wol_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  wol_pkg::pixel_t               pixel,
  input  logic [wol_pkg::THR_W-1:0]     thresh,
  input  logic [wol_pkg::POS_W-1:0]     wm1,
  input  logic [wol_pkg::POS_W-1:0]     hm1,
  input  logic [wol_pkg::POS_W-1:0]     left_edge,
  input  logic [wol_pkg::POS_W-1:0]     right_edge,
  input  logic                          s0_move,
  output wol_pkg::pix_word_t            s0
);

  logic [wol_pkg::POS_W-1:0] col_r, col_nxt;
  logic [wol_pkg::POS_W-1:0] row_r, row_nxt;
  wol_pkg::pix_word_t        s0_r, s0_nxt;
  logic                      row_end;
  logic                      frame_end;
  logic                      white;
  wol_pkg::band_t            band;

  always_comb begin
    white = (pixel.red == pixel.green) && (pixel.red == pixel.blue) &&
            (pixel.red >= thresh);
    if (col_r < left_edge) begin
      band = wol_pkg::BAND_LEFT;
    end else if (col_r > right_edge) begin
      band = wol_pkg::BAND_RIGHT;
    end else begin
      band = wol_pkg::BAND_CENTRE;
    end
    row_end   = col_r >= wm1;
    frame_end = row_end && (row_r >= hm1);

    col_nxt = col_r;
    row_nxt = row_r;
    s0_nxt  = s0_r;
    if (in_fire) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
      s0_nxt.valid     = 1'b1;
      s0_nxt.white     = white;
      s0_nxt.band      = band;
      s0_nxt.frame_end = frame_end;
    end else if (s0_move) begin
      s0_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s0_r     <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      s0_r  <= s0_nxt;
    end
  end

  assign s0 = s0_r;

endmodule

// ===== sv/wol_count.sv =====
module wol_count (
  input  logic               clk,
  input  logic               rst_n,
  input  wol_pkg::pix_word_t s0,
  input  logic               s0_move,
  input  logic               fin_move,
  output wol_pkg::fin_word_t fin
);

  logic [wol_pkg::CNT_W-1:0] left_r, left_nxt;
  logic [wol_pkg::CNT_W-1:0] centre_r, centre_nxt;
  logic [wol_pkg::CNT_W-1:0] right_r, right_nxt;
  logic [wol_pkg::CNT_W-1:0] left_upd, centre_upd, right_upd;
  wol_pkg::fin_word_t        fin_r, fin_nxt;
  logic                      take;

  function automatic logic [wol_pkg::CNT_W-1:0] bump(input logic [wol_pkg::CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  always_comb begin
    take       = s0.valid && s0_move;
    left_upd   = left_r;
    centre_upd = centre_r;
    right_upd  = right_r;
    if (s0.white) begin
      case (s0.band)
        wol_pkg::BAND_LEFT:   left_upd   = bump(left_r);
        wol_pkg::BAND_RIGHT:  right_upd  = bump(right_r);
        default:              centre_upd = bump(centre_r);
      endcase
    end

    left_nxt   = left_r;
    centre_nxt = centre_r;
    right_nxt  = right_r;
    fin_nxt    = fin_r;
    if (fin_move) begin
      fin_nxt.valid = 1'b0;
    end
    if (take) begin
      if (s0.frame_end) begin
        // snapshot the finished frame, start the next one clean
        fin_nxt.valid  = 1'b1;
        fin_nxt.left   = left_upd;
        fin_nxt.centre = centre_upd;
        fin_nxt.right  = right_upd;
        left_nxt       = '0;
        centre_nxt     = '0;
        right_nxt      = '0;
      end else begin
        left_nxt   = left_upd;
        centre_nxt = centre_upd;
        right_nxt  = right_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= '0;
      centre_r  <= '0;
      right_r   <= '0;
      fin_r     <= '0;
    end else begin
      left_r   <= left_nxt;
      centre_r <= centre_nxt;
      right_r  <= right_nxt;
      fin_r    <= fin_nxt;
    end
  end

  assign fin = fin_r;

endmodule

// ===== sv/wol_decide.sv =====
module wol_decide (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wol_pkg::fin_word_t          fin,
  input  logic [wol_pkg::LIMIT_W-1:0] close_limit,
  output logic                        fin_move,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wol_pkg::result_t            out_data
);

  logic [wol_pkg::TOTAL_W-1:0] total;
  logic                        report;
  wol_pkg::result_t            res;
  logic                        out_valid_r, out_valid_nxt;
  wol_pkg::result_t            out_data_r, out_data_nxt;

  always_comb begin
    total = wol_pkg::TOTAL_W'(fin.left) + wol_pkg::TOTAL_W'(fin.centre) +
            wol_pkg::TOTAL_W'(fin.right);
    report = (total != '0) && (total < wol_pkg::TOTAL_W'(close_limit));
    res = '0;
    if (report) begin
      if ((fin.left >= fin.centre) && (fin.left >= fin.right)) begin
        res.object_left = 1'b1;
      end else if (fin.centre >= fin.right) begin
        res.object_centre = 1'b1;
      end else begin
        res.object_right = 1'b1;
      end
    end

    fin_move      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (fin_move) begin
      out_valid_nxt = fin.valid;
      if (fin.valid) begin
        out_data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/white_object_region_locator_top.sv =====
// channel   direction  word                          handshake
// in_       input      pixel_t  red, green, blue     in_valid / in_ready
// out_      output     result_t left, centre, right  out_valid / out_ready
// cfg_      input      index + data register write   cfg_valid / cfg_ready
//
// one pixel word accepted per clock while in_ready is high; three register stages (classify,
// count, decide) carry a frame result to out_ after the last pixel
// synchronous active-low reset; in_ready stays low the cycle after reset and
// after each register write while the band limits are recomputed
// a stalled out_ blocks in_ only once the finished-frame slot is full too
// and a further frame-end pixel waits behind it
module white_object_region_locator_top #(
  parameter int unsigned MAX_DIMENSION = wol_pkg::MAX_DIMENSION_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wol_pkg::pixel_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wol_pkg::result_t                 out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wol_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wol_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // largest dimension the row and column compares can see
  localparam logic [wol_pkg::POS_W-1:0] DimCap =
    (MAX_DIMENSION > 4095) ? 12'hFFF : MAX_DIMENSION[wol_pkg::POS_W-1:0];

  // configuration registers
  logic [wol_pkg::POS_W-1:0]   width_r, width_nxt;
  logic [wol_pkg::POS_W-1:0]   height_r, height_nxt;
  logic [wol_pkg::THR_W-1:0]   thresh_r, thresh_nxt;
  logic [wol_pkg::LIMIT_W-1:0] close_r, close_nxt;

  // derived limits, recomputed every cycle from the registers
  logic [wol_pkg::POS_W-1:0]   w_clamp, h_clamp;
  logic [wol_pkg::POS_W-1:0]   wm1_r, hm1_r, left_edge_r, right_edge_r;
  logic                        lim_ok_r;
  logic                        cfg_fire;

  // pipeline control
  wol_pkg::pix_word_t          s0;
  wol_pkg::fin_word_t          fin;
  logic                        fin_move;
  logic                        s0_move;
  logic                        in_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // register write decode, wide data is truncated to the field width
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    thresh_nxt = thresh_r;
    close_nxt  = close_r;
    if (cfg_fire) begin
      unique case (cfg_index)
        wol_pkg::REG_WIDTH:  width_nxt  = cfg_data[wol_pkg::POS_W-1:0];
        wol_pkg::REG_HEIGHT: height_nxt = cfg_data[wol_pkg::POS_W-1:0];
        wol_pkg::REG_THRESH: thresh_nxt = cfg_data[wol_pkg::THR_W-1:0];
        wol_pkg::REG_CLOSE:  close_nxt  = cfg_data[wol_pkg::LIMIT_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // zero acts as one, oversize acts as the cap
  always_comb begin
    if (width_r == '0) begin
      w_clamp = 12'd1;
    end else if (width_r > DimCap) begin
      w_clamp = DimCap;
    end else begin
      w_clamp = width_r;
    end
    if (height_r == '0) begin
      h_clamp = 12'd1;
    end else if (height_r > DimCap) begin
      h_clamp = DimCap;
    end else begin
      h_clamp = height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= wol_pkg::WIDTH_RST;
      height_r <= wol_pkg::HEIGHT_RST;
      thresh_r <= wol_pkg::THRESH_RST;
      close_r  <= wol_pkg::CLOSE_RST;
      lim_ok_r <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      thresh_r <= thresh_nxt;
      close_r  <= close_nxt;
      // limits are stale in the cycle after any write
      lim_ok_r <= !cfg_fire;
    end
  end

  // band edges: width/3 and 2*width/3 via reciprocal multiply
  always_ff @(posedge clk) begin
    wm1_r        <= w_clamp - 1'b1;
    hm1_r        <= h_clamp - 1'b1;
    left_edge_r  <= wol_pkg::div3({1'b0, w_clamp});
    right_edge_r <= wol_pkg::div3({w_clamp, 1'b0});
  end

  // a frame-end word waits only if the finished-frame slot is still full
  assign s0_move  = !(s0.valid && s0.frame_end && fin.valid && !fin_move);
  assign in_ready = lim_ok_r && (!s0.valid || s0_move);
  assign in_fire  = in_valid && in_ready;

  wol_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .pixel      (in_data),
    .thresh     (thresh_r),
    .wm1        (wm1_r),
    .hm1        (hm1_r),
    .left_edge  (left_edge_r),
    .right_edge (right_edge_r),
    .s0_move    (s0_move),
    .s0         (s0)
  );

  wol_count u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .s0       (s0),
    .s0_move  (s0_move),
    .fin_move (fin_move),
    .fin      (fin)
  );

  wol_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .fin         (fin),
    .close_limit (close_r),
    .fin_move    (fin_move),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== sv/wol_checker.sv =====
`include "white_object_region_locator_top_macros.svh"

module wol_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input wol_pkg::result_t out_data,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  `WOL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_data), "result word changed while stalled")

  `WOL_ASSERT_NOW(a_onehot_result, out_valid, $onehot0(out_data),
                  "result word not one-hot or zero")

  `WOL_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !in_ready,
                   "pixel taken while limits stale")

  `WOL_ASSERT_NOW(a_reset_blocks_input, !$past(rst_n), !in_ready,
                  "pixel taken right after reset")

endmodule

bind white_object_region_locator_top wol_checker u_wol_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
